// ===== hw/rtl/grid_neighbor_address_generator_defines.svh =====
// assertion macros for the grid neighbor address generator
`ifndef GRID_NEIGHBOR_ADDRESS_GENERATOR_DEFINES_SVH
`define GRID_NEIGHBOR_ADDRESS_GENERATOR_DEFINES_SVH

// same-cycle implication
`define GNAG_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
        else $error("gnag assertion failed");

// next-cycle implication
`define GNAG_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
        else $error("gnag assertion failed");

`endif

// ===== hw/rtl/gnag_pkg.sv =====
// shared types, constants and offset tables for the grid neighbor address generator
`default_nettype none

package gnag_pkg;

    localparam int COORD_W     = 6;
    localparam int DIM_W       = 7;
    localparam int INDEX_W     = 18;
    localparam int CFG_INDEX_W = 2;
    localparam int MOORE_COUNT = 26;
    localparam int VN_COUNT    = 6;
    localparam int SLOT_W      = $clog2(MOORE_COUNT);
    localparam int VN_IDX_W    = $clog2(VN_COUNT);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_DEPTH  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_NBHD_MODE   = 2'd3;

    localparam logic MODE_MOORE       = 1'b0;
    localparam logic MODE_VON_NEUMANN = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd5;

    typedef enum logic [1:0] {
        OFS_NEG,
        OFS_ZERO,
        OFS_POS
    } axis_ofs_t;

    typedef struct packed {
        axis_ofs_t dz;
        axis_ofs_t dy;
        axis_ofs_t dx;
    } ofs_t;

    typedef struct packed {
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_z;
    } query_t;

    typedef struct packed {
        logic [INDEX_W-1:0] neighbor_index;
        logic [COORD_W-1:0] neighbor_x;
        logic [COORD_W-1:0] neighbor_y;
        logic [COORD_W-1:0] neighbor_z;
        logic               last_neighbor;
    } result_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] depth;
        logic             mode;
    } grid_cfg_t;

    typedef struct packed {
        query_t                 target;
        logic                   mode;
        logic [MOORE_COUNT-1:0] slots;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

    // z outermost, then y, then x; center skipped
    localparam ofs_t MOORE_OFS [MOORE_COUNT] = '{
        '{OFS_NEG,  OFS_NEG,  OFS_NEG}, '{OFS_NEG,  OFS_NEG,  OFS_ZERO},
        '{OFS_NEG,  OFS_NEG,  OFS_POS}, '{OFS_NEG,  OFS_ZERO, OFS_NEG},
        '{OFS_NEG,  OFS_ZERO, OFS_ZERO}, '{OFS_NEG,  OFS_ZERO, OFS_POS},
        '{OFS_NEG,  OFS_POS,  OFS_NEG}, '{OFS_NEG,  OFS_POS,  OFS_ZERO},
        '{OFS_NEG,  OFS_POS,  OFS_POS}, '{OFS_ZERO, OFS_NEG,  OFS_NEG},
        '{OFS_ZERO, OFS_NEG,  OFS_ZERO}, '{OFS_ZERO, OFS_NEG,  OFS_POS},
        '{OFS_ZERO, OFS_ZERO, OFS_NEG}, '{OFS_ZERO, OFS_ZERO, OFS_POS},
        '{OFS_ZERO, OFS_POS,  OFS_NEG}, '{OFS_ZERO, OFS_POS,  OFS_ZERO},
        '{OFS_ZERO, OFS_POS,  OFS_POS}, '{OFS_POS,  OFS_NEG,  OFS_NEG},
        '{OFS_POS,  OFS_NEG,  OFS_ZERO}, '{OFS_POS,  OFS_NEG,  OFS_POS},
        '{OFS_POS,  OFS_ZERO, OFS_NEG}, '{OFS_POS,  OFS_ZERO, OFS_ZERO},
        '{OFS_POS,  OFS_ZERO, OFS_POS}, '{OFS_POS,  OFS_POS,  OFS_NEG},
        '{OFS_POS,  OFS_POS,  OFS_ZERO}, '{OFS_POS,  OFS_POS,  OFS_POS}
    };

    // -x, +x, -y, +y, -z, +z
    localparam ofs_t VN_OFS [VN_COUNT] = '{
        '{OFS_ZERO, OFS_ZERO, OFS_NEG}, '{OFS_ZERO, OFS_ZERO, OFS_POS},
        '{OFS_ZERO, OFS_NEG,  OFS_ZERO}, '{OFS_ZERO, OFS_POS,  OFS_ZERO},
        '{OFS_NEG,  OFS_ZERO, OFS_ZERO}, '{OFS_POS,  OFS_ZERO, OFS_ZERO}
    };

    function automatic ofs_t slot_offset(input logic mode, input logic [SLOT_W-1:0] slot);
        ofs_t r;
        r = '{OFS_ZERO, OFS_ZERO, OFS_ZERO};
        if (mode == MODE_VON_NEUMANN)
        begin
            if (slot < SLOT_W'(VN_COUNT))
            begin
                r = VN_OFS[slot[VN_IDX_W-1:0]];
            end
        end
        else if (slot < SLOT_W'(MOORE_COUNT))
        begin
            r = MOORE_OFS[slot];
        end
        return r;
    endfunction

    function automatic logic slot_count_ok(input logic mode, input logic [SLOT_W-1:0] slot);
        logic ok;
        if (mode == MODE_VON_NEUMANN)
        begin
            ok = slot < SLOT_W'(VN_COUNT);
        end
        else
        begin
            ok = slot < SLOT_W'(MOORE_COUNT);
        end
        return ok;
    endfunction

    function automatic logic [DIM_W-1:0] step_coord(input logic [COORD_W-1:0] c,
                                                    input axis_ofs_t o);
        logic [DIM_W-1:0] r;
        case (o)
            OFS_NEG:  r = {1'b0, c} - 1'b1;
            OFS_POS:  r = {1'b0, c} + 1'b1;
            OFS_ZERO: r = {1'b0, c};
            default:  r = {1'b0, c};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/grid_neighbor_address_generator.sv =====
// top level: configuration registers, classifier, item queue and emitter
//
//  channel   direction  handshake             payload
//  query     in         start / busy          query_t (cell_x, cell_y, cell_z)
//  result    out        result_strobe         result_t (index, x, y, z, last)
//  config    in         cfg_we                cfg_index, cfg_data
//
// one result beat per clock for each in-grid neighbor (up to 26, or 6 in von neumann
// mode); a cell with no neighbor is dropped by the classifier and gives no result
// first result path: classifier register, queue, emitter, s1, s2 and output registers
// busy rises only when the four-entry queue and the classifier register are both full
// results cannot be held off; reset clears all control state, no clearing pass
`default_nettype none

module grid_neighbor_address_generator
    import gnag_pkg::*;
#(
    parameter int MAX_GRID_DIM = 64
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire query_t                 query,
    output logic                        result_strobe,
    output result_t                     result,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]       cfg_data
);

    localparam int DIM_MAX_VAL = (MAX_GRID_DIM > (1 << DIM_W) - 1) ? (1 << DIM_W) - 1
                                                                 : MAX_GRID_DIM;
    localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(DIM_MAX_VAL);

    grid_cfg_t   cfg_reg;
    queue_stat_t qstat;
    logic        push;
    item_t       push_item;
    logic        pop;
    item_t       head_item;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_CAP)
        begin
            r = DIM_CAP;
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= DIM_RESET;
            cfg_reg.height <= DIM_RESET;
            cfg_reg.depth  <= DIM_RESET;
            cfg_reg.mode   <= MODE_MOORE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  cfg_reg.width  <= clamp_dim(cfg_data);
                REG_GRID_HEIGHT: cfg_reg.height <= clamp_dim(cfg_data);
                REG_GRID_DEPTH:  cfg_reg.depth  <= clamp_dim(cfg_data);
                REG_NBHD_MODE:   cfg_reg.mode   <= cfg_data[0];
                default:         cfg_reg        <= cfg_reg;
            endcase
        end
    end

    gnag_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .query     (query),
        .cfg       (cfg_reg),
        .qstat     (qstat),
        .busy      (busy),
        .push      (push),
        .push_item (push_item)
    );

    gnag_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .stat      (qstat)
    );

    gnag_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .head_item     (head_item),
        .qstat         (qstat),
        .pop           (pop),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/gnag_queue.sv =====
// small item queue between the classifier and the emitter
`default_nettype none

module gnag_queue
    import gnag_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire item_t       push_item,
    input  wire logic        pop,
    output item_t            head_item,
    output queue_stat_t      stat
);

    item_t                  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_item  = entry_reg[rd_ptr_reg];

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gnag_front.sv =====
// input stage: takes a query cell and works out which neighbor slots are in the grid
`default_nettype none

module gnag_front
    import gnag_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire query_t      query,
    input  wire grid_cfg_t   cfg,
    input  wire queue_stat_t qstat,
    output logic             busy,
    output logic             push,
    output item_t            push_item
);

    logic                   fr_valid_reg, fr_valid_next;
    item_t                  fr_item_reg;
    logic                   accept;
    logic                   in_grid;
    logic [MOORE_COUNT-1:0] slots;

    function automatic logic axis_ok(input axis_ofs_t o, input logic lo_ok, input logic hi_ok);
        logic r;
        case (o)
            OFS_NEG:  r = lo_ok;
            OFS_POS:  r = hi_ok;
            OFS_ZERO: r = 1'b1;
            default:  r = 1'b0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        logic x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
        ofs_t ofs_k;
        x_lo = (query.cell_x != '0);
        y_lo = (query.cell_y != '0);
        z_lo = (query.cell_z != '0);
        x_hi = (({1'b0, query.cell_x} + 1'b1) < cfg.width);
        y_hi = (({1'b0, query.cell_y} + 1'b1) < cfg.height);
        z_hi = (({1'b0, query.cell_z} + 1'b1) < cfg.depth);
        in_grid = ({1'b0, query.cell_x} < cfg.width)
               && ({1'b0, query.cell_y} < cfg.height)
               && ({1'b0, query.cell_z} < cfg.depth);
        for (int k = 0; k < MOORE_COUNT; k++)
        begin
            ofs_k = slot_offset(cfg.mode, SLOT_W'(k));
            slots[k] = in_grid && slot_count_ok(cfg.mode, SLOT_W'(k))
                    && axis_ok(ofs_k.dx, x_lo, x_hi)
                    && axis_ok(ofs_k.dy, y_lo, y_hi)
                    && axis_ok(ofs_k.dz, z_lo, z_hi);
        end
    end

    assign busy      = fr_valid_reg && qstat.full;
    assign accept    = start && !busy;
    assign push      = fr_valid_reg && !qstat.full;
    assign push_item = fr_item_reg;

    always_comb
    begin
        fr_valid_next = fr_valid_reg && qstat.full;
        if (accept)
        begin
            // a cell with no neighbor in the grid is dropped here
            fr_valid_next = (slots != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fr_item_reg.target <= query;
            fr_item_reg.mode   <= cfg.mode;
            fr_item_reg.slots  <= slots;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gnag_back.sv =====
// emitter: walks the in-grid slots of one item and computes coordinates and linear index
`default_nettype none

module gnag_back
    import gnag_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire grid_cfg_t   cfg,
    input  wire item_t       head_item,
    input  wire queue_stat_t qstat,
    output logic             pop,
    output logic             result_strobe,
    output result_t          result
);

    typedef struct packed {
        logic [DIM_W-1:0] nx;
        logic [DIM_W-1:0] ny;
        logic [DIM_W-1:0] nz;
        logic             last;
    } coord_beat_t;

    typedef struct packed {
        logic [DIM_W-1:0]     nx;
        logic [DIM_W-1:0]     ny;
        logic [DIM_W-1:0]     nz;
        logic [2*DIM_W-1:0]   py;
        logic [INDEX_W-1:0]   pz;
        logic                 last;
    } prod_beat_t;

    query_t                 cur_cell_reg;
    logic                   cur_mode_reg;
    logic [MOORE_COUNT-1:0] cur_rem_reg, cur_rem_next;
    logic [2*DIM_W-1:0]     wh_reg;

    logic [MOORE_COUNT-1:0] pick;
    logic [MOORE_COUNT-1:0] rem_after;
    logic [SLOT_W-1:0]      slot;
    logic                   emit;
    logic                   finishing;
    ofs_t                   ofs;
    coord_beat_t            coord;

    logic                   s1_valid_reg;
    coord_beat_t            s1_reg;
    logic                   s2_valid_reg;
    prod_beat_t             s2_reg;
    logic                   out_valid_reg;
    result_t                out_reg;
    logic [3*DIM_W-1:0]     pz_full;

    assign emit      = (cur_rem_reg != '0);
    assign pick      = cur_rem_reg & (~cur_rem_reg + 1'b1);
    assign rem_after = cur_rem_reg & ~pick;
    assign finishing = emit && (rem_after == '0);
    assign pop       = (!emit || finishing) && !qstat.empty;

    always_comb
    begin
        slot = '0;
        for (int i = 0; i < MOORE_COUNT; i++)
        begin
            if (pick[i])
            begin
                slot = slot | SLOT_W'(i);
            end
        end
    end

    assign ofs        = slot_offset(cur_mode_reg, slot);
    assign coord.nx   = step_coord(cur_cell_reg.cell_x, ofs.dx);
    assign coord.ny   = step_coord(cur_cell_reg.cell_y, ofs.dy);
    assign coord.nz   = step_coord(cur_cell_reg.cell_z, ofs.dz);
    assign coord.last = finishing;

    always_comb
    begin
        cur_rem_next = cur_rem_reg;
        if (pop)
        begin
            cur_rem_next = head_item.slots;
        end
        else if (emit)
        begin
            cur_rem_next = rem_after;
        end
    end

    assign pz_full = (3*DIM_W)'(s1_reg.nz) * (3*DIM_W)'(wh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_rem_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_rem_reg   <= cur_rem_next;
            s1_valid_reg  <= emit;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wh_reg <= (2*DIM_W)'(cfg.width) * (2*DIM_W)'(cfg.height);
        if (pop)
        begin
            cur_cell_reg <= head_item.target;
            cur_mode_reg <= head_item.mode;
        end
        s1_reg      <= coord;
        s2_reg.nx   <= s1_reg.nx;
        s2_reg.ny   <= s1_reg.ny;
        s2_reg.nz   <= s1_reg.nz;
        s2_reg.last <= s1_reg.last;
        s2_reg.py   <= (2*DIM_W)'(s1_reg.ny) * (2*DIM_W)'(cfg.width);
        s2_reg.pz   <= pz_full[INDEX_W-1:0];
        out_reg.neighbor_index <= INDEX_W'(s2_reg.nx) + INDEX_W'(s2_reg.py) + s2_reg.pz;
        out_reg.neighbor_x     <= s2_reg.nx[COORD_W-1:0];
        out_reg.neighbor_y     <= s2_reg.ny[COORD_W-1:0];
        out_reg.neighbor_z     <= s2_reg.nz[COORD_W-1:0];
        out_reg.last_neighbor  <= s2_reg.last;
    end

    assign result_strobe = out_valid_reg;
    assign result        = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/gnag_checker.sv =====
// port-level checks for the grid neighbor address generator, bound to the top level
`default_nettype none

`include "grid_neighbor_address_generator_defines.svh"

module gnag_checker
    import gnag_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    result_strobe,
    input wire result_t result
);

    // busy only comes from an accepted beat or holds over
    `GNAG_ASSERT_IMP(a_busy_cause, clk, rst_n, busy, $past(busy) || $past(start && !busy))

    // nothing comes out of the pipeline right after reset
    `GNAG_ASSERT_IMP(a_no_early_result, clk, rst_n, result_strobe, $past(rst_n, 4))

    // the beats of one cell come without gaps
    `GNAG_ASSERT_NXT(a_burst_gapless, clk, rst_n, result_strobe && !result.last_neighbor, result_strobe)

endmodule

bind grid_neighbor_address_generator gnag_checker u_gnag_checker (.*);

`default_nettype wire
